FILE: rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants for the MIPS subset core
// Instruction field codes, item payload structs and the data memory request.
// ----------------------------------------------------------------------------
package msc_pkg;

  // major opcodes (instruction bits 31..26)
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type ALU select, funct bits 2..0
  localparam logic [2:0] FN_ADDU = 3'd1;
  localparam logic [2:0] FN_SUBU = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_NOR  = 3'd7;

  localparam logic [31:0] HALT_WORD      = 32'hffff_ffff;
  localparam logic [31:0] PC_REGION_MASK = 32'hf000_0000;

  // item kinds
  localparam logic ITEM_EXEC = 1'b0;
  localparam logic ITEM_LOAD = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] instruction;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
  } msc_in_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [31:0] mem_word;
    logic        bad_operation;
  } msc_out_t;

  // data memory request; addr is wrapped inside the memory
  typedef struct packed {
    logic        store;  // write word big-endian at addr
    logic        poke;   // write byte word[7:0] at addr
    logic        fetch;  // read word at addr, data next cycle
    logic [31:0] addr;
    logic [31:0] word;
  } msc_mem_req_t;

endpackage

FILE: rtl/msc_cmd_if.sv
// ----------------------------------------------------------------------------
// msc_cmd_if: input item channel
// Valid/ready handshake carrying one execute or load item.
// ----------------------------------------------------------------------------
interface msc_cmd_if import msc_pkg::*; ();
  logic    valid;
  logic    ready;
  msc_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/msc_res_if.sv
// ----------------------------------------------------------------------------
// msc_res_if: result item channel
// Valid/ready handshake carrying one result item per input item.
// ----------------------------------------------------------------------------
interface msc_res_if import msc_pkg::*; ();
  logic     valid;
  logic     ready;
  msc_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/msc_dmem.sv
// ----------------------------------------------------------------------------
// msc_dmem: byte data memory with unaligned big-endian word access
// Four byte banks selected by address bits 1..0; a word touches each bank
// once, so any word (also one wrapping past the top) is one access.
// ----------------------------------------------------------------------------
module msc_dmem import msc_pkg::*; #(
  parameter int DATA_BYTES = 65536
) (
  input  logic         clk,
  input  msc_mem_req_t req,
  output logic [31:0]  rd_word
);

  localparam int AW   = $clog2(DATA_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = DATA_BYTES / 4;

  logic [AW-1:0] addr_w;
  logic [RW-1:0] base;
  logic [1:0]    lane;
  logic [1:0]    lane_q;
  logic [RW-1:0] row [4];
  logic [1:0]    slot [4];
  logic [7:0]    wd [4];
  logic [3:0]    we;
  logic [7:0]    q [4];

  always_comb begin
    addr_w = req.addr[AW-1:0];
    base   = addr_w[AW-1:2];
    lane   = addr_w[1:0];
    for (int k = 0; k < 4; k++) begin
      // byte position within the word that lands in bank k
      slot[k] = 2'(k) - lane;
      // banks below the starting lane hold bytes of the next row
      row[k]  = base + RW'(2'(k) < lane);
      we[k]   = req.store | (req.poke & (lane == 2'(k)));
      wd[k]   = req.poke ? req.word[7:0] : req.word[8 * (3 - int'(slot[k])) +: 8];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] bank_mem [ROWS];

    always_ff @(posedge clk) begin
      if (we[k]) begin
        bank_mem[row[k]] <= wd[k];
      end
      if (req.fetch) begin
        q[k] <= bank_mem[row[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.fetch) begin
      lane_q <= lane;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_word[8 * (3 - i) +: 8] = q[lane_q + 2'(i)];
    end
  end

endmodule

FILE: rtl/mips_subset_single_cycle_core_top.sv
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core_top: MIPS subset core, one word per item
// Results leave via the output register after execute; lw also passes load
// writeback. Throughput: one item per cycle while res is ready; an lw holds
// intake while its synchronous data memory read completes before writeback.
// Reset: clears PC, halt flag and register file valid bits (registers read 0);
// data memory is not cleared.
// ----------------------------------------------------------------------------
module mips_subset_single_cycle_core_top import msc_pkg::*; #(
  parameter int DATA_BYTES = 65536
) (
  input logic             clk,
  input logic             rst,
  msc_cmd_if.sink         cmd,
  msc_res_if.source       res
);

  localparam int AW = $clog2(DATA_BYTES);

  // architectural state
  logic [31:0] pc;
  logic        halt;
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid;

  // decode/execute stage
  logic        s1_valid;
  msc_in_t     s1_item;
  logic [31:0] rf_a_q, rf_b_q;
  logic        rf_a_ok, rf_b_ok;
  logic        byp_a, byp_b;
  logic [31:0] byp_data;

  // load writeback stage
  logic        s2_valid;
  logic [4:0]  s2_rt;

  // output register
  logic        res_valid;
  msc_out_t    res_q;

  logic         cmd_fire;
  logic         out_free;
  logic         s1_done;
  logic         s1_lw;
  logic         lw_move;
  logic         s2_adv;
  logic [31:0]  ins;
  logic [5:0]   opcode;
  logic [4:0]   rs, rt, rd;
  logic [31:0]  imm;
  logic [31:0]  a, b;
  logic [31:0]  pc4;
  logic [31:0]  sum;
  logic         exec, is_halt, run;
  logic [31:0]  alu;
  logic         alu_ok;
  msc_out_t     s1_res;
  msc_out_t     s2_res;
  logic         wr_en;
  logic [4:0]   wr_addr;
  logic [31:0]  wr_data;
  logic [4:0]   cmd_rs, cmd_rt;
  msc_mem_req_t mem_req;
  logic [31:0]  mem_rd;

  // ---------------- execute ----------------
  always_comb begin
    ins     = s1_item.instruction;
    opcode  = ins[31:26];
    rs      = ins[25:21];
    rt      = ins[20:16];
    rd      = ins[15:11];
    imm     = {{16{ins[15]}}, ins[15:0]};
    a       = byp_a ? byp_data : (rf_a_ok ? rf_a_q : 32'd0);
    b       = byp_b ? byp_data : (rf_b_ok ? rf_b_q : 32'd0);
    pc4     = pc + 32'd4;
    sum     = a + imm;
    exec    = (s1_item.operation == ITEM_EXEC) && !halt;
    is_halt = exec && (ins == HALT_WORD);
    run     = exec && !is_halt;

    alu_ok = 1'b1;
    unique case (ins[2:0])
      FN_ADDU: alu = a + b;
      FN_SUBU: alu = a - b;
      FN_AND:  alu = a & b;
      FN_OR:   alu = a | b;
      FN_NOR:  alu = ~(a | b);
      default: begin
        alu    = 32'd0;
        alu_ok = 1'b0;
      end
    endcase

    s1_res         = '0;
    s1_res.next_pc = pc;
    s1_res.halted  = halt | is_halt;
    if (run) begin
      s1_res.next_pc = pc4;
      unique case (opcode)
        OP_RTYPE: begin
          if (alu_ok) begin
            s1_res.reg_written = 1'b1;
            s1_res.reg_index   = rd;
            s1_res.reg_value   = alu;
          end else begin
            s1_res.bad_operation = 1'b1;
          end
        end
        OP_J: s1_res.next_pc = (pc4 & PC_REGION_MASK) | {4'b0, ins[25:0], 2'b00};
        OP_BEQ: begin
          if (a == b) begin
            s1_res.next_pc = pc4 + {imm[29:0], 2'b00};
          end
        end
        OP_ADDIU: begin
          s1_res.reg_written = 1'b1;
          s1_res.reg_index   = rt;
          s1_res.reg_value   = sum;
        end
        OP_SW: begin
          s1_res.mem_written = 1'b1;
          s1_res.mem_address = 16'(sum[AW-1:0]);
          s1_res.mem_word    = b;
        end
        default: ;  // lw finishes in the writeback stage; others only move pc
      endcase
    end
  end

  // ---------------- flow control ----------------
  always_comb begin
    s1_lw    = s1_valid && run && (opcode == OP_LW);
    out_free = !res_valid || res.ready;
    s2_adv   = s2_valid && out_free;
    s1_done  = s1_valid && !s1_lw && out_free && !s2_valid;
    lw_move  = s1_lw;
    // intake only when the stage holding an item writes back this cycle,
    // so the bypass below catches every pending register write
    cmd.ready = (!s1_valid || s1_done) && (!s2_valid || s2_adv) && !s1_lw;
    cmd_fire  = cmd.valid && cmd.ready;
  end

  // ---------------- register file ----------------
  always_comb begin
    wr_en   = (s1_done && s1_res.reg_written) || s2_adv;
    wr_addr = s2_valid ? s2_rt : s1_res.reg_index;
    wr_data = s2_valid ? mem_rd : s1_res.reg_value;
    cmd_rs  = cmd.payload.instruction[25:21];
    cmd_rt  = cmd.payload.instruction[20:16];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
    if (cmd_fire) begin
      rf_a_q   <= rf_mem[cmd_rs];
      rf_b_q   <= rf_mem[cmd_rt];
      rf_a_ok  <= rf_valid[cmd_rs];
      rf_b_ok  <= rf_valid[cmd_rt];
      byp_a    <= wr_en && (wr_addr == cmd_rs);
      byp_b    <= wr_en && (wr_addr == cmd_rt);
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (wr_en) begin
      rf_valid[wr_addr] <= 1'b1;
    end
  end

  // ---------------- data memory ----------------
  always_comb begin
    mem_req       = '0;
    mem_req.store = s1_done && run && (opcode == OP_SW);
    mem_req.poke  = s1_done && (s1_item.operation == ITEM_LOAD);
    mem_req.fetch = lw_move;
    mem_req.addr  = mem_req.poke ? 32'(s1_item.load_address) : sum;
    mem_req.word  = mem_req.poke ? 32'(s1_item.load_byte) : b;
  end

  msc_dmem #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dmem (
    .clk     (clk),
    .req     (mem_req),
    .rd_word (mem_rd)
  );

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pc       <= '0;
      halt     <= 1'b0;
    end else begin
      if (cmd_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_done || lw_move) begin
        s1_valid <= 1'b0;
      end
      if (lw_move) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s1_done || lw_move) begin
        pc   <= s1_res.next_pc;
        halt <= s1_res.halted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_item <= cmd.payload;
    end
    if (lw_move) begin
      s2_rt <= rt;
    end
  end

  always_comb begin
    s2_res             = '0;
    s2_res.next_pc     = pc;
    s2_res.halted      = halt;
    s2_res.reg_written = 1'b1;
    s2_res.reg_index   = s2_rt;
    s2_res.reg_value   = mem_rd;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_done || s2_adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      res_q <= s2_res;
    end else if (s1_done) begin
      res_q <= s1_res;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_q;

  // ---------------- assertions ----------------
  a_stage_excl: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s2_valid))
    else $error("execute and load writeback stages both occupied");

  a_lw_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_lw) |-> !cmd_fire)
    else $error("item accepted while lw waits for data memory");

  a_lw_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_lw) |=> (s2_valid && !s1_valid))
    else $error("lw did not move to writeback");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt)
    else $error("halt flag cleared without reset");

endmodule
